[hw/rtl/artt_pkg.sv]
// shared types, codes and sizes for the ack retry timeout table
package artt_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int SLOT_W = 4;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_ACK      = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [2:0] K_REGISTERED  = 3'd0;
  localparam logic [2:0] K_ACK_OK      = 3'd1;
  localparam logic [2:0] K_ACK_MISSING = 3'd2;
  localparam logic [2:0] K_STATUS      = 3'd3;
  localparam logic [2:0] K_RETRY       = 3'd4;
  localparam logic [2:0] K_TIMEOUT     = 3'd5;
  localparam logic [2:0] K_TICK_DONE   = 3'd6;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_ACKED     = 2'd1;
  localparam logic [1:0] ST_TIMED_OUT = 2'd2;

  localparam logic [7:0] CFG_TIMEOUT     = 8'd0;
  localparam logic [7:0] CFG_MAX_RETRIES = 8'd1;

  localparam logic [19:0] TIMEOUT_RESET = 20'd5000;
  localparam logic [7:0]  RETRIES_RESET = 8'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              has_slot;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       delta_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] out_slot;
    logic [1:0]        status;
    logic [7:0]        retries;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic expired;
    logic may_retry;
  } expiry_t;

endpackage

[hw/rtl/ack_retry_timeout_table.sv]
// top level of the ack retry timeout table: sequencer, slot store and result register
//
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     in_data   (opcode, has_slot, slot, delta_ms)
// out      output     out_valid / out_ready   out_data  (kind, out_slot, status, retries, last)
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// register, acknowledge and query read the slot in the exec state; once the result register is free
// the result is registered and the table returns to idle, ready again
// a tick visits one slot a cycle, unless a stalled result holds the scan, through the single
// age comparator and the one read port of the sent-time and retry-count memories
// reset clears the valid and acked flags at once; there is no clearing pass
// a stalled result holds the sequencer only once it has a new result to give; the scan
// goes on past slots that give none; cfg_ready is always high
module ack_retry_timeout_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  artt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output artt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [19:0]         cfg_data
);
  import artt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] next_id_r, next_id_nxt;
  logic [31:0]       clock_r, clock_nxt;
  logic [19:0]       timeout_r;
  logic [7:0]        max_retries_r;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  acked_r, acked_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [31:0]       sent_mem [SLOTS];
  logic [7:0]        cnt_mem  [SLOTS];
  logic [31:0]       rd_sent_r;
  logic [7:0]        rd_cnt_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [31:0]       wr_sent;
  logic [7:0]        wr_cnt;

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              live;
  logic              pend;
  logic              out_free;
  logic              accept;
  logic [SLOT_W:0]   id_inc;
  expiry_t           exp;

  artt_expiry u_expiry (
    .clock_ms    (clock_r),
    .sent_at     (rd_sent_r),
    .timeout_ms  (timeout_r),
    .retry_count (rd_cnt_r),
    .max_retries (max_retries_r),
    .result      (exp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign idx       = slot_r[IDX_W-1:0];
  assign in_range  = ({1'b0, slot_r} < (SLOT_W+1)'(SLOTS));
  assign live      = in_range && valid_r[idx];
  assign pend      = valid_r[idx] && !acked_r[idx];
  assign id_inc    = {1'b0, next_id_r} + (SLOT_W+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    next_id_nxt   = next_id_r;
    clock_nxt     = clock_r;
    valid_nxt     = valid_r;
    acked_nxt     = acked_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = idx;
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_sent       = clock_r;
    wr_cnt        = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.opcode;
          slot_nxt  = in_data.slot;
          state_nxt = S_EXEC;
          rd_en     = 1'b1;
          rd_addr   = in_data.slot[IDX_W-1:0];
          if (in_data.opcode == OP_TICK) begin
            clock_nxt = clock_r + {16'd0, in_data.delta_ms};
            slot_nxt  = '0;
            rd_addr   = '0;
          end else if (in_data.opcode == OP_REGISTER && !in_data.has_slot) begin
            slot_nxt    = next_id_r;
            next_id_nxt = (id_inc >= (SLOT_W+1)'(SLOTS)) ? '0 : id_inc[SLOT_W-1:0];
          end
        end
      end

      S_EXEC: begin
        if (op_r == OP_TICK) begin
          if (!(pend && exp.expired) || out_free) begin
            if (pend && exp.expired) begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.out_slot = slot_r;
              out_data_nxt.last     = 1'b0;
              if (exp.may_retry) begin
                wr_en                = 1'b1;
                wr_cnt               = rd_cnt_r + 8'd1;
                out_data_nxt.kind    = K_RETRY;
                out_data_nxt.status  = ST_PENDING;
                out_data_nxt.retries = wr_cnt;
              end else begin
                valid_nxt[idx]       = 1'b0;
                out_data_nxt.kind    = K_TIMEOUT;
                out_data_nxt.status  = ST_TIMED_OUT;
                out_data_nxt.retries = rd_cnt_r;
              end
            end
            if (idx == IDX_W'(SLOTS - 1)) begin
              state_nxt = S_DONE;
            end else begin
              slot_nxt = slot_r + SLOT_W'(1);
              rd_en    = 1'b1;
              rd_addr  = idx + IDX_W'(1);
            end
          end
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.out_slot = slot_r;
          out_data_nxt.last     = 1'b1;
          out_data_nxt.status   = ST_PENDING;
          out_data_nxt.retries  = 8'd0;
          state_nxt             = S_IDLE;
          case (op_r)
            OP_REGISTER: begin
              out_data_nxt.kind = K_REGISTERED;
              if (in_range) begin
                valid_nxt[idx] = 1'b1;
                acked_nxt[idx] = 1'b0;
                wr_en          = 1'b1;
              end
            end
            OP_ACK: begin
              if (live) begin
                acked_nxt[idx]       = 1'b1;
                out_data_nxt.kind    = K_ACK_OK;
                out_data_nxt.status  = ST_ACKED;
                out_data_nxt.retries = rd_cnt_r;
              end else begin
                out_data_nxt.kind = K_ACK_MISSING;
              end
            end
            default: begin
              out_data_nxt.kind = K_STATUS;
              if (live) begin
                out_data_nxt.status  = acked_r[idx] ? ST_ACKED : ST_PENDING;
                out_data_nxt.retries = rd_cnt_r;
              end
            end
          endcase
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.kind     = K_TICK_DONE;
          out_data_nxt.out_slot = '0;
          out_data_nxt.status   = ST_PENDING;
          out_data_nxt.retries  = 8'd0;
          out_data_nxt.last     = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sent_r <= sent_mem[rd_addr];
      rd_cnt_r  <= cnt_mem[rd_addr];
    end
    if (wr_en) begin
      sent_mem[wr_addr] <= wr_sent;
      cnt_mem[wr_addr]  <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      next_id_r     <= '0;
      clock_r       <= '0;
      valid_r       <= '0;
      acked_r       <= '0;
      out_valid_r   <= 1'b0;
      timeout_r     <= TIMEOUT_RESET;
      max_retries_r <= RETRIES_RESET;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      clock_r     <= clock_nxt;
      valid_r     <= valid_nxt;
      acked_r     <= acked_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT:     timeout_r     <= cfg_data;
          CFG_MAX_RETRIES: max_retries_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[hw/rtl/artt_expiry.sv]
// shared age and retry-limit comparator used by the tick scan
module artt_expiry (
  input  logic [31:0]      clock_ms,
  input  logic [31:0]      sent_at,
  input  logic [19:0]      timeout_ms,
  input  logic [7:0]       retry_count,
  input  logic [7:0]       max_retries,
  output artt_pkg::expiry_t result
);
  import artt_pkg::*;

  logic [31:0] age;

  assign age              = clock_ms - sent_at;
  assign result.expired   = (age >= {12'd0, timeout_ms});
  assign result.may_retry = (retry_count < max_retries);

endmodule

[hw/rtl/artt_checker.sv]
// port-level checker for the ack retry timeout table, bound to the top level
module artt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input artt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input artt_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [7:0]          cfg_index,
  input logic [19:0]         cfg_data
);
  import artt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after a request");

  a_only_scan_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.kind == K_RETRY || out_data.kind == K_TIMEOUT)
    else $error("non-final result that is not a retry or timeout");

  a_tick_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_TICK_DONE |->
      out_data.last && out_data.out_slot == '0 && out_data.status == ST_PENDING &&
      out_data.retries == 8'd0)
    else $error("malformed tick done result");

  a_timeout_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_TIMEOUT |-> out_data.status == ST_TIMED_OUT)
    else $error("timeout result without timed out status");

endmodule

bind ack_retry_timeout_table artt_checker u_artt_checker (.*);
